// File: sv/clmd_pkg.sv
// shared types, constants and helpers for the content-length deframer
package clmd_pkg;

    localparam int LEN_BITS = 24;
    localparam int CFG_BITS = 24;
    localparam int LV_BITS  = LEN_BITS + 1;
    localparam int MUL_BITS = LEN_BITS + 5;
    localparam int CMP_BITS = (LV_BITS > CFG_BITS) ? LV_BITS : CFG_BITS;

    localparam logic [LEN_BITS:0] LEN_CAP = {1'b1, {LEN_BITS{1'b0}}};

    localparam logic [3:0] KEY_LEN     = 4'd14;
    localparam logic [3:0] KEY_NOMATCH = 4'd15;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic {
        PH_HEADER,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        LS_NONE,
        LS_VALID,
        LS_BAD
    } len_state_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MISSING,
        ST_BADLEN,
        ST_TRUNC
    } status_t;

    typedef struct packed {
        logic started;
        logic ended;
        logic digits;
        logic keyok;
        logic colon;
    } line_flags_t;

    typedef struct packed {
        logic       eos;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic       last;
        logic       body_valid;
        logic [7:0] body_byte;
    } result_t;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: sv/clmd_in_stage.sv
// input register stage of the deframer
module clmd_in_stage
    import clmd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_item_t s_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     in_valid_reg;
    logic     in_valid_next;
    in_item_t in_item_reg;

    assign s_tready   = !in_valid_reg || advance;
    assign item_valid = in_valid_reg;
    assign item       = in_item_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= s_item;
        end
    end

endmodule

// File: sv/clmd_parser.sv
// header parser, body counter and length limit register
module clmd_parser
    import clmd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_BITS-1:0] cfg_wr_data,
    input  logic                step,
    input  in_item_t            item,
    output logic                res_valid,
    output result_t             res
);

    logic [CFG_BITS-1:0] max_len_reg;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [1:0]          sep_reg;
    logic [1:0]          sep_next;
    logic [3:0]          key_idx_reg;
    logic [3:0]          key_idx_next;
    line_flags_t         flags_reg;
    line_flags_t         flags_next;
    logic [LV_BITS-1:0]  len_val_reg;
    logic [LV_BITS-1:0]  len_val_next;
    len_state_t          len_st_reg;
    len_state_t          len_st_next;
    logic [LEN_BITS-1:0] remain_reg;
    logic [LEN_BITS-1:0] remain_next;

    logic [7:0]          b;
    logic [MUL_BITS-1:0] acc_ext;
    logic [MUL_BITS-1:0] acc_sum;
    logic                too_big;
    logic                is_last;

    assign b       = item.data;
    assign acc_ext = MUL_BITS'(len_val_reg);
    assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + MUL_BITS'(b[3:0]);
    assign too_big = len_val_reg[LEN_BITS]
        || (CMP_BITS'(len_val_reg) > CMP_BITS'(max_len_reg));
    assign is_last = (remain_reg <= LEN_BITS'(1));

    always_comb
    begin
        phase_next   = phase_reg;
        sep_next     = sep_reg;
        key_idx_next = key_idx_reg;
        flags_next   = flags_reg;
        len_val_next = len_val_reg;
        len_st_next  = len_st_reg;
        remain_next  = remain_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (step)
        begin
            if (item.eos)
            begin
                res_valid    = (phase_reg == PH_BODY) || flags_reg.started;
                res.last     = 1'b1;
                res.status   = ST_TRUNC;
                phase_next   = PH_HEADER;
                sep_next     = '0;
                key_idx_next = '0;
                flags_next   = '0;
                len_val_next = '0;
                len_st_next  = LS_NONE;
                remain_next  = '0;
            end
            else if (phase_reg == PH_BODY)
            begin
                res_valid      = 1'b1;
                res.body_byte  = b;
                res.body_valid = 1'b1;
                res.last       = is_last;
                res.status     = ST_OK;
                remain_next    = is_last ? '0 : remain_reg - LEN_BITS'(1);
                if (is_last)
                begin
                    phase_next = PH_HEADER;
                end
            end
            else if (sep_reg == 2'd3 && b == CH_LF)
            begin
                // end of header block
                sep_next     = '0;
                key_idx_next = '0;
                flags_next   = '0;
                len_val_next = '0;
                len_st_next  = LS_NONE;
                remain_next  = '0;
                res.last     = 1'b1;
                if (len_st_reg == LS_NONE)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_MISSING;
                end
                else if (len_st_reg == LS_BAD || too_big)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_BADLEN;
                end
                else if (len_val_reg == '0)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_OK;
                end
                else
                begin
                    phase_next  = PH_BODY;
                    remain_next = len_val_reg[LEN_BITS-1:0];
                end
            end
            else
            begin
                flags_next.started = 1'b1;
                if ((sep_reg == 2'd0 || sep_reg == 2'd2) && b == CH_CR)
                begin
                    sep_next = sep_reg + 2'd1;
                end
                else if (sep_reg == 2'd1 && b == CH_LF)
                begin
                    sep_next = 2'd2;
                end
                else
                begin
                    sep_next = (b == CH_CR) ? 2'd1 : 2'd0;
                end

                if (b == CH_LF)
                begin
                    // line end
                    if (flags_reg.keyok)
                    begin
                        len_st_next = flags_reg.digits ? LS_VALID : LS_BAD;
                    end
                    flags_next         = '0;
                    flags_next.started = 1'b1;
                    key_idx_next       = '0;
                end
                else if (!flags_reg.colon)
                begin
                    if (b == CH_COLON)
                    begin
                        flags_next.colon = 1'b1;
                        if (key_idx_reg == KEY_LEN)
                        begin
                            flags_next.keyok = 1'b1;
                            len_val_next     = '0;
                        end
                    end
                    else if (key_idx_reg < KEY_LEN && b == key_char(key_idx_reg))
                    begin
                        key_idx_next = key_idx_reg + 4'd1;
                    end
                    else
                    begin
                        key_idx_next = KEY_NOMATCH;
                    end
                end
                else if (flags_reg.keyok && !flags_reg.ended)
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        len_val_next = (acc_sum > MUL_BITS'(LEN_CAP))
                            ? LEN_CAP : acc_sum[LV_BITS-1:0];
                        flags_next.digits = 1'b1;
                    end
                    else if (!flags_reg.digits && (b == CH_SP || b == CH_TAB
                        || b == CH_CR || b == CH_VT || b == CH_FF))
                    begin
                        // leading white space
                        flags_next.ended = 1'b0;
                    end
                    else
                    begin
                        flags_next.ended = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= '1;
            phase_reg   <= PH_HEADER;
            sep_reg     <= '0;
            key_idx_reg <= '0;
            flags_reg   <= '0;
            len_val_reg <= '0;
            len_st_reg  <= LS_NONE;
            remain_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            sep_reg     <= sep_next;
            key_idx_reg <= key_idx_next;
            flags_reg   <= flags_next;
            len_val_reg <= len_val_next;
            len_st_reg  <= len_st_next;
            remain_reg  <= remain_next;
        end
    end

`ifndef SYNTHESIS
    a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> remain_reg != '0)
        else $error("body phase with no bytes left");

    a_header_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> remain_reg == '0)
        else $error("byte count left over in header phase");

    a_ended_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.ended |-> (flags_reg.keyok && flags_reg.colon))
        else $error("value end without a matching key");

    a_body_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.body_valid) |-> (res.status == ST_OK
        && phase_reg == PH_BODY))
        else $error("body byte out of body phase");
`endif

endmodule

// File: sv/clmd_out_stage.sv
// result register of the deframer
module clmd_out_stage
    import clmd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    output logic    out_free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_res    = out_res_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

endmodule

// File: sv/content_length_message_deframer_core.sv
// top level of the content-length message deframer
// usage:
// - the slave channel takes one stream byte per transaction in s_tdata,
//   with s_tlast marking end of stream (the byte is then ignored)
// - the master channel gives body bytes in m_tdata, m_tuser[0] set when
//   a byte is carried and m_tuser[2:1] the status code; m_tlast marks the
//   final body byte, an empty message, an error or a truncation
// - the header is consumed silently; only body bytes, empty messages,
//   errors and truncations produce a master transaction
// - cfg_wr_en / cfg_wr_data set the largest accepted body length; write it
//   only while the block is idle
// - a result passes the input register and then the result register before it is presented
// - throughput: one byte per cycle while m_tready is high, set by the single
//   parser stage between the input register and the result register
// - when m_tready is low the result register holds and s_tready drops once
//   the input register also holds a byte, whether or not it makes a result
// - reset clears the valid flags of both registers and all parser state and
//   sets the length limit to its maximum
module content_length_message_deframer_core
    import clmd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,  // data_byte
    input  logic                s_tlast,  // end_of_stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,  // body_byte
    output logic [2:0]          m_tuser,  // body_valid, status[1:0]
    output logic                m_tlast,  // last_of_message
    input  logic                cfg_wr_en,
    input  logic [CFG_BITS-1:0] cfg_wr_data
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_free;
    logic     advance;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_item.data = s_tdata;
    assign s_item.eos  = s_tlast;
    assign advance     = item_valid && out_free;

    clmd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    clmd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .item        (item),
        .res_valid   (res_valid),
        .res         (res)
    );

    clmd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = m_res.body_byte;
    assign m_tuser = {m_res.status, m_res.body_valid};
    assign m_tlast = m_res.last;

endmodule
